### rtl/core/lik_pkg.sv
// shared types, constants and helper functions for the leg inverse kinematics block
package lik_pkg;

  localparam int LIK_CORDIC_STEPS = 16;
  localparam int ATAN_TAB_LEN     = 24;

  localparam logic [2:0] REG_OFFSET_X     = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z     = 3'd2;
  localparam logic [2:0] REG_FEMUR_LENGTH = 3'd3;
  localparam logic [2:0] REG_TIBIA_LENGTH = 3'd4;

  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;

  localparam logic signed [17:0] YAW_LO   = -18'sd25736;
  localparam logic signed [17:0] YAW_HI   = 18'sd25736;
  localparam logic signed [17:0] FEMUR_LO = -18'sd12868;
  localparam logic signed [17:0] FEMUR_HI = 18'sd38604;
  localparam logic signed [17:0] TIBIA_LO = 18'sd0;
  localparam logic signed [17:0] TIBIA_HI = 18'sd25736;

  localparam logic [14:0] LEN_RESET = 15'd256;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837830;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // round q30 half up to q13 and clamp
  function automatic logic signed [17:0] to_q13(input logic signed [34:0] a,
                                                input logic signed [17:0] lo,
                                                input logic signed [17:0] hi);
    logic signed [35:0] s;
    logic signed [18:0] r;
    s = 36'(a) + 36'sd65536;
    r = 19'(s >>> 17);
    if (r < 19'(lo)) r = 19'(lo);
    if (r > 19'(hi)) r = 19'(hi);
    return 18'(r);
  endfunction

endpackage

### rtl/core/lik_ifs.sv
// handshake channel interfaces for target, result and register writes
interface lik_target_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface lik_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [16:0] femur_angle;
  logic        [14:0] tibia_angle;
  logic               reachable;
  modport source (output valid, yaw_angle, femur_angle, tibia_angle, reachable, input ready);
  modport sink   (input valid, yaw_angle, femur_angle, tibia_angle, reachable, output ready);
endinterface

interface lik_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/three_joint_leg_inverse_kinematics_top.sv
// leg inverse kinematics top: sequencer, shared multiplier, root and cordic units
// a reachable target passes the squaring products, the sums and the reach check, then two more
//   products, two square roots and four cordic passes (yaw, tibia, then two for the femur)
// an unreachable target returns straight after the reach check, with angles held
// one item at a time; the next target is taken the cycle after the result is issued
// reset: offsets 0, segment lengths 256, held angles 0, no result pending
module three_joint_leg_inverse_kinematics_top
  import lik_pkg::*;
#(
  parameter int CORDIC_STEPS = LIK_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst,
  lik_target_if.sink   target,
  lik_result_if.source result,
  lik_cfg_if.sink      cfg
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SQRT1 = 4'd5;
  localparam logic [3:0] S_SQRT2 = 4'd6;
  localparam logic [3:0] S_ANG   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]         state;
  logic [3:0]         step;
  logic signed [15:0] off_x;
  logic signed [15:0] off_y;
  logic signed [15:0] off_z;
  logic [14:0]        femur_len;
  logic [14:0]        tibia_len;
  logic signed [16:0] xa;
  logic signed [16:0] ya;
  logic signed [16:0] za;
  logic [14:0]        f;
  logic [14:0]        t;
  logic [32:0]        xx;
  logic [32:0]        yy;
  logic [32:0]        zz;
  logic [29:0]        ff;
  logic [29:0]        tt;
  logic [29:0]        ft;
  logic [29:0]        dd;
  logic [31:0]        ss;
  logic [33:0]        h2;
  logic [34:0]        l2;
  logic signed [35:0] n3;
  logic signed [35:0] mb;
  logic [61:0]        tf2;
  logic [61:0]        an2;
  logic [30:0]        s_root;
  logic [24:0]        hq;
  logic signed [33:0] yaw_z;
  logic signed [33:0] tib_z;
  logic signed [34:0] fem_z;
  logic signed [15:0] held_yaw;
  logic signed [16:0] held_femur;
  logic [14:0]        held_tibia;
  logic               reach_r;
  logic               sq_start;
  logic               sq_sel;
  logic               cd_start;
  logic [1:0]         cd_sel;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic signed [15:0] dft;
  logic [15:0]        sft;
  logic               reach_ok;
  logic [63:0]        sq_rad;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic signed [36:0] cd_y;
  logic signed [36:0] cd_x;
  logic               cd_done;
  logic signed [33:0] cd_angle;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  assign target.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x     <= '0;
      off_y     <= '0;
      off_z     <= '0;
      femur_len <= LEN_RESET;
      tibia_len <= LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OFFSET_X:     off_x     <= cfg.data;
        REG_OFFSET_Y:     off_y     <= cfg.data;
        REG_OFFSET_Z:     off_z     <= cfg.data;
        REG_FEMUR_LENGTH: femur_len <= cfg.data[14:0];
        REG_TIBIA_LENGTH: tibia_len <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dft = 16'(f) - 16'(t);
    sft = 16'(f) + 16'(t);
    unique case (step)
      4'd0:    begin mul_a = 32'(abs17(xa)); mul_b = 32'(abs17(xa)); end
      4'd1:    begin mul_a = 32'(abs17(ya)); mul_b = 32'(abs17(ya)); end
      4'd2:    begin mul_a = 32'(abs17(za)); mul_b = 32'(abs17(za)); end
      4'd3:    begin mul_a = 32'(f); mul_b = 32'(f); end
      4'd4:    begin mul_a = 32'(t); mul_b = 32'(t); end
      4'd5:    begin mul_a = 32'(f); mul_b = 32'(t); end
      4'd6:    begin mul_a = 32'(abs17(17'(dft))); mul_b = 32'(abs17(17'(dft))); end
      4'd7:    begin mul_a = 32'(sft); mul_b = 32'(sft); end
      4'd8:    begin mul_a = 32'({ft, 1'b0}); mul_b = 32'({ft, 1'b0}); end
      4'd9:    begin
        mul_a = n3[35] ? 32'(-n3) : 32'(n3);
        mul_b = mul_a;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);

    reach_ok = (f != '0) && (t != '0) && (l2 != '0) && (35'(dd) <= l2) && (l2 <= 35'(ss));

    sq_rad = sq_sel ? {14'd0, h2, 16'd0} : 64'(tf2 - an2);

    unique case (cd_sel)
      2'd0:    begin cd_y = 37'(ya); cd_x = 37'(xa); end
      2'd1:    begin cd_y = 37'(s_root); cd_x = 37'(n3); end
      2'd2:    begin cd_y = 37'(s_root); cd_x = 37'(mb); end
      default: begin cd_y = 37'($signed({za, 8'd0})); cd_x = 37'(hq); end
    endcase
  end

  lik_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  lik_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .in_y  (cd_y),
    .in_x  (cd_x),
    .done  (cd_done),
    .angle (cd_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      sq_start     <= 1'b0;
      sq_sel       <= 1'b0;
      cd_start     <= 1'b0;
      cd_sel       <= '0;
      held_yaw     <= '0;
      held_femur   <= '0;
      held_tibia   <= '0;
      reach_r      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      cd_start <= 1'b0;
      if (result.valid && result.ready && state != S_OUT) result.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (target.valid) begin
            xa    <= 17'(target.target_x) + 17'(off_x);
            ya    <= 17'(target.target_y) + 17'(off_y);
            za    <= 17'(target.target_z) + 17'(off_z);
            f     <= femur_len;
            t     <= tibia_len;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (step)
            4'd0:    xx <= prod[32:0];
            4'd1:    yy <= prod[32:0];
            4'd2:    zz <= prod[32:0];
            4'd3:    ff <= prod[29:0];
            4'd4:    tt <= prod[29:0];
            4'd5:    ft <= prod[29:0];
            4'd6:    dd <= prod[29:0];
            default: ss <= prod[31:0];
          endcase
          step <= step + 4'd1;
          if (step == 4'd7) state <= S_SUM;
        end
        S_SUM: begin
          h2    <= 34'(xx) + 34'(yy);
          l2    <= 35'(xx) + 35'(yy) + 35'(zz);
          state <= S_CHECK;
        end
        S_CHECK: begin
          n3   <= 36'(ff) + 36'(tt) - 36'(l2);
          mb   <= 36'(l2) + 36'(ff) - 36'(tt);
          step <= 4'd8;
          if (reach_ok) begin
            state <= S_MUL2;
          end else begin
            reach_r <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_MUL2: begin
          step <= step + 4'd1;
          if (step == 4'd8) begin
            tf2 <= prod[61:0];
          end else begin
            an2      <= prod[61:0];
            sq_sel   <= 1'b0;
            sq_start <= 1'b1;
            state    <= S_SQRT1;
          end
        end
        S_SQRT1: begin
          if (sq_done) begin
            s_root   <= sq_root[30:0];
            sq_sel   <= 1'b1;
            sq_start <= 1'b1;
            state    <= S_SQRT2;
          end
        end
        S_SQRT2: begin
          if (sq_done) begin
            hq       <= sq_root[24:0];
            cd_sel   <= 2'd0;
            cd_start <= 1'b1;
            state    <= S_ANG;
          end
        end
        S_ANG: begin
          if (cd_done) begin
            unique case (cd_sel)
              2'd0:    yaw_z <= cd_angle;
              2'd1:    tib_z <= cd_angle;
              2'd2:    fem_z <= 35'(cd_angle);
              default: fem_z <= fem_z + 35'(cd_angle);
            endcase
            if (cd_sel == 2'd3) begin
              state <= S_FIN;
            end else begin
              cd_sel   <= cd_sel + 2'd1;
              cd_start <= 1'b1;
            end
          end
        end
        S_FIN: begin
          held_yaw   <= 16'(to_q13(35'(yaw_z), YAW_LO, YAW_HI));
          held_femur <= 17'(to_q13(fem_z, FEMUR_LO, FEMUR_HI));
          held_tibia <= 15'(to_q13(35'(tib_z), TIBIA_LO, TIBIA_HI));
          reach_r    <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.yaw_angle   <= held_yaw;
            result.femur_angle <= held_femur;
            result.tibia_angle <= held_tibia;
            result.reachable   <= reach_r;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !reach_ok) |=> ($stable(held_yaw) && $stable(held_femur)
                                         && $stable(held_tibia)))
    else $error("held angles changed on unreachable target");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (target.valid && target.ready) |=> !target.ready)
    else $error("target taken while solving");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(sq_start && cd_start))
    else $error("root and cordic launched together");

endmodule

### rtl/core/lik_isqrt.sv
// iterative integer square root, one result bit per cycle
module lik_isqrt
  import lik_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bit_r;
  logic        busy;
  logic [63:0] sum;
  logic [63:0] v_next;
  logic [63:0] res_next;

  always_comb begin
    sum = res + bit_r;
    if (v >= sum) begin
      v_next   = v - sum;
      res_next = (res >> 1) + bit_r;
    end else begin
      v_next   = v;
      res_next = res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy  <= 1'b1;
          v     <= radicand;
          res   <= '0;
          bit_r <= 64'h4000_0000_0000_0000;
        end
      end else begin
        v     <= v_next;
        res   <= res_next;
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= res_next[31:0];
        end
      end
    end
  end

endmodule

### rtl/core/lik_cordic.sv
// vectoring cordic atan2 with pre-normalization, one micro-rotation per cycle
module lik_cordic
  import lik_pkg::*;
#(
  parameter int STEPS = LIK_CORDIC_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [36:0]  in_y,
  input  logic signed [36:0]  in_x,
  output logic                done,
  output logic signed [33:0]  angle
);

  localparam int         NSTEP = (STEPS < ATAN_TAB_LEN) ? STEPS : ATAN_TAB_LEN;
  localparam logic [4:0] LAST  = 5'(NSTEP - 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  logic [1:0]         state;
  logic signed [43:0] x;
  logic signed [43:0] y;
  logic signed [33:0] z;
  logic [4:0]         i;
  logic signed [43:0] ex;
  logic signed [43:0] ey;
  logic [43:0]        ax;
  logic [43:0]        ay;
  logic [43:0]        mag;
  logic signed [43:0] dx;
  logic signed [43:0] dy;
  logic signed [33:0] at;
  logic signed [33:0] z_next;

  always_comb begin
    ex     = 44'(in_x);
    ey     = 44'(in_y);
    ax     = x[43] ? 44'(-x) : 44'(x);
    ay     = y[43] ? 44'(-y) : 44'(y);
    mag    = (ax > ay) ? ax : ay;
    dx     = y >>> i;
    dy     = x >>> i;
    at     = 34'(atan_q30(i));
    z_next = y[43] ? z - at : z + at;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            i <= '0;
            if (in_x == '0 && in_y == '0) begin
              angle <= '0;
              done  <= 1'b1;
            end else begin
              state <= C_NORM;
              if (!in_x[36]) begin
                x <= ex;
                y <= ey;
                z <= '0;
              end else if (!in_y[36]) begin
                x <= ey;
                y <= -ex;
                z <= ANG_HALF_PI;
              end else begin
                x <= -ey;
                y <= ex;
                z <= -ANG_HALF_PI;
              end
            end
          end
        end
        C_NORM: begin
          if (mag < 44'h100_0000_0000 >> 8) begin
            x <= x <<< 8;
            y <= y <<< 8;
          end else if (mag < 44'h100_0000_0000) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (!y[43]) begin
            x <= x + dx;
            y <= y - dy;
          end else begin
            x <= x - dx;
            y <= y + dy;
          end
          z <= z_next;
          i <= i + 5'd1;
          if (i == LAST) begin
            angle <= z_next;
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
